// ----- src/bcc_pkg.sv -----
// shared constants and types for the block compare cache
`timescale 1ns / 1ps

package bcc_pkg;

  localparam int BLOCK_BYTES  = 4096;
  localparam int BYTE_W       = 8;
  localparam int SUM_W        = 32;
  localparam int LEN_W        = 13;
  localparam int SHIFT_PERIOD = 8;
  localparam int SHIFT_W      = $clog2(SHIFT_PERIOD);
  localparam int ADDR_W       = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam int POS_W        = ($clog2(BLOCK_BYTES + 1) > LEN_W) ?
                                $clog2(BLOCK_BYTES + 1) : LEN_W;
  localparam int FIFO_DEPTH   = 2;
  localparam int FIFO_IDX_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic             matched;
    logic [SUM_W-1:0] block_checksum;
    logic [LEN_W-1:0] stored_length;
    logic             too_long;
  } result_t;

endpackage

// ----- src/bcc_ram.sv -----
// one bank of block bytes: one write port, one registered read port
`timescale 1ns / 1ps

module bcc_ram (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [bcc_pkg::ADDR_W-1:0]    wr_addr,
  input  logic [bcc_pkg::BYTE_W-1:0]    wr_data,
  input  logic                          rd_en,
  input  logic [bcc_pkg::ADDR_W-1:0]    rd_addr,
  output logic [bcc_pkg::BYTE_W-1:0]    rd_data
);

  logic [bcc_pkg::BYTE_W-1:0] mem [bcc_pkg::BLOCK_BYTES];
  logic [bcc_pkg::BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/bcc_out_fifo.sv -----
// two-entry result buffer between the compare stage and the output channel
`timescale 1ns / 1ps

module bcc_out_fifo (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  bcc_pkg::result_t                push_data,
  input  logic                            pop,
  output logic                            head_valid,
  output bcc_pkg::result_t                head_data,
  output logic [bcc_pkg::FIFO_CNT_W-1:0]  count
);

  bcc_pkg::result_t                 mem_r [bcc_pkg::FIFO_DEPTH];
  logic [bcc_pkg::FIFO_IDX_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [bcc_pkg::FIFO_CNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign count      = cnt_r;

endmodule

// ----- src/block_compare_cache_core.sv -----
// top level of the block compare cache: byte tracking, bank compare, result logic
`timescale 1ns / 1ps

// Single-entry block cache fed one byte per item. A block is a run of items
// closed by one with in_block_end set; in_no_data marks an item without a byte.
// Each byte is compared against the stored block and written into a staging
// bank; two banks swap roles at block end when the block replaces the store.
// Input channel: in_valid / in_stall, accepted when valid and not stalled.
// Result channel: out_valid / out_stall, one result per block_end item only.
// Result path: the block_end item and its bank read are registered into the compare
// stage, which compares, updates the store and pushes the result into the buffer.
// Throughput: one item per cycle while not stalled; each item needs one read of
// both banks and one write into the staging bank, all on separate ports.
// A two-entry result buffer lets items keep flowing while a result waits;
// in_stall rises only when the buffer could not take a further result, so a
// stalled receiver holds the input back after at most two pending results.
// Reset: the store is empty (length 0, checksum 0) and valid, and no block is
// in progress. The banks are not cleared: only written positions are compared.

module block_compare_cache_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic                           in_overwrite,
  input  logic [bcc_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic                           in_no_data,
  input  logic                           in_block_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_matched,
  output logic [bcc_pkg::SUM_W-1:0]      out_block_checksum,
  output logic [bcc_pkg::LEN_W-1:0]      out_stored_length,
  output logic                           out_too_long
);

  localparam logic [bcc_pkg::POS_W-1:0] CAP = bcc_pkg::POS_W'(bcc_pkg::BLOCK_BYTES);

  // ---------------- byte tracking (accept side) ----------------
  logic                          accept;
  logic [bcc_pkg::POS_W-1:0]     pos_r, pos_after;
  logic [bcc_pkg::SUM_W-1:0]     running_sum_r, sum_after;
  logic                          ovf_r, ovf_after;
  logic                          room, take0;

  // ---------------- compare stage ----------------
  logic                          s1_v_r;
  logic [bcc_pkg::BYTE_W-1:0]    s1_byte_r;
  logic                          s1_take_r;
  logic [bcc_pkg::POS_W-1:0]     s1_pos_r, s1_len_r;
  logic [bcc_pkg::SUM_W-1:0]     s1_sum_r;
  logic                          s1_ovf_r, s1_end_r, s1_op_r, s1_ow_r;

  logic                          fwd_v_r, fwd_bank_r;
  logic [bcc_pkg::BYTE_W-1:0]    fwd_data_r;

  logic                          sel_r, sel_nxt;
  logic [bcc_pkg::POS_W-1:0]     stored_len_r, stored_len_nxt;
  logic [bcc_pkg::SUM_W-1:0]     stored_sum_r, stored_sum_nxt;
  logic                          store_valid_r, store_valid_nxt;
  logic                          all_equal_r, all_equal_nxt;

  logic [bcc_pkg::BYTE_W-1:0]    rd0, rd1, d0, d1, stored_byte;
  logic                          s1_wr, eq_now, ae, same, replace;
  logic                          push, pop;
  bcc_pkg::result_t              res, head;
  logic [bcc_pkg::FIFO_CNT_W-1:0] fifo_cnt;
  logic [bcc_pkg::FIFO_CNT_W:0]  occ, limit;

  assign accept    = in_valid && !in_stall;
  assign room      = (pos_r < CAP);
  assign take0     = !in_no_data && room;
  assign pos_after = take0 ? pos_r + 1'b1 : pos_r;
  assign sum_after = take0 ?
                     running_sum_r + (bcc_pkg::SUM_W'(in_data_byte)
                                      << pos_r[bcc_pkg::SHIFT_W-1:0]) :
                     running_sum_r;
  assign ovf_after = ovf_r | (!in_no_data && !room);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      running_sum_r <= '0;
      ovf_r         <= 1'b0;
    end else if (accept) begin
      if (in_block_end) begin
        pos_r         <= '0;
        running_sum_r <= '0;
        ovf_r         <= 1'b0;
      end else begin
        pos_r         <= pos_after;
        running_sum_r <= sum_after;
        ovf_r         <= ovf_after;
      end
    end
  end

  // staging write happens in the compare stage, into the bank not holding the store
  assign s1_wr = s1_v_r && s1_take_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      if (accept) begin
        // read and write of the same position across a block boundary
        fwd_v_r <= s1_wr && (s1_pos_r[bcc_pkg::ADDR_W-1:0] == pos_r[bcc_pkg::ADDR_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r  <= in_data_byte;
      s1_take_r  <= take0;
      s1_pos_r   <= pos_r;
      s1_len_r   <= pos_after;
      s1_sum_r   <= sum_after;
      s1_ovf_r   <= ovf_after;
      s1_end_r   <= in_block_end;
      s1_op_r    <= in_operation;
      s1_ow_r    <= in_overwrite;
      fwd_bank_r <= ~sel_r;
      fwd_data_r <= s1_byte_r;
    end
  end

  bcc_ram u_bank0 (
    .clk     (clk),
    .wr_en   (s1_wr && sel_r),
    .wr_addr (s1_pos_r[bcc_pkg::ADDR_W-1:0]),
    .wr_data (s1_byte_r),
    .rd_en   (accept),
    .rd_addr (pos_r[bcc_pkg::ADDR_W-1:0]),
    .rd_data (rd0)
  );

  bcc_ram u_bank1 (
    .clk     (clk),
    .wr_en   (s1_wr && !sel_r),
    .wr_addr (s1_pos_r[bcc_pkg::ADDR_W-1:0]),
    .wr_data (s1_byte_r),
    .rd_en   (accept),
    .rd_addr (pos_r[bcc_pkg::ADDR_W-1:0]),
    .rd_data (rd1)
  );

  assign d0          = (fwd_v_r && !fwd_bank_r) ? fwd_data_r : rd0;
  assign d1          = (fwd_v_r &&  fwd_bank_r) ? fwd_data_r : rd1;
  assign stored_byte = sel_r ? d1 : d0;

  assign eq_now  = !s1_take_r || ((s1_pos_r < stored_len_r) && (s1_byte_r == stored_byte));
  assign ae      = all_equal_r & eq_now;
  assign same    = store_valid_r && (s1_len_r == stored_len_r) && ae;
  assign replace = s1_op_r || (!same && s1_ow_r);
  assign push    = s1_v_r && s1_end_r;

  always_comb begin
    sel_nxt         = sel_r;
    stored_len_nxt  = stored_len_r;
    stored_sum_nxt  = stored_sum_r;
    store_valid_nxt = store_valid_r;
    all_equal_nxt   = all_equal_r;
    if (s1_v_r) begin
      all_equal_nxt = ae;
      if (s1_end_r) begin
        all_equal_nxt = 1'b1;
        if (s1_ovf_r) begin
          store_valid_nxt = 1'b0;
          stored_len_nxt  = '0;
          stored_sum_nxt  = '0;
        end else if (replace) begin
          sel_nxt         = ~sel_r;
          stored_len_nxt  = s1_len_r;
          stored_sum_nxt  = s1_sum_r;
          store_valid_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r         <= 1'b0;
      stored_len_r  <= '0;
      stored_sum_r  <= '0;
      store_valid_r <= 1'b1;
      all_equal_r   <= 1'b1;
    end else begin
      sel_r         <= sel_nxt;
      stored_len_r  <= stored_len_nxt;
      stored_sum_r  <= stored_sum_nxt;
      store_valid_r <= store_valid_nxt;
      all_equal_r   <= all_equal_nxt;
    end
  end

  assign res.matched        = !s1_ovf_r && !s1_op_r && same;
  assign res.block_checksum = stored_sum_nxt;
  assign res.stored_length  = stored_len_nxt[bcc_pkg::LEN_W-1:0];
  assign res.too_long       = s1_ovf_r;

  // ---------------- result buffer ----------------
  assign pop = out_valid && !out_stall;

  bcc_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (res),
    .pop        (pop),
    .head_valid (out_valid),
    .head_data  (head),
    .count      (fifo_cnt)
  );

  // an item in the compare stage may still push a result
  assign occ      = {1'b0, fifo_cnt} + (bcc_pkg::FIFO_CNT_W + 1)'(s1_v_r);
  assign limit    = (bcc_pkg::FIFO_CNT_W + 1)'(bcc_pkg::FIFO_DEPTH - 1)
                    + (bcc_pkg::FIFO_CNT_W + 1)'(pop);
  assign in_stall = (occ > limit);

  assign out_matched        = head.matched;
  assign out_block_checksum = head.block_checksum;
  assign out_stored_length  = head.stored_length;
  assign out_too_long       = head.too_long;

  // ---------------- assertions ----------------
  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> fifo_cnt < bcc_pkg::FIFO_CNT_W'(bcc_pkg::FIFO_DEPTH))
    else $error("result buffer overflow");

  a_too_long_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_long |-> out_stored_length == '0 && out_block_checksum == '0
                                  && !out_matched)
    else $error("too long block did not clear the store");

  a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    stored_len_r <= CAP)
    else $error("stored length beyond capacity");

  a_invalid_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !store_valid_r |-> stored_len_r == '0 && stored_sum_r == '0)
    else $error("invalid store holds a length or checksum");

endmodule
